>>> src/oaht_pkg.sv
`timescale 1ns / 1ps
package oaht_pkg;
  localparam int SLOTS = 256;
  localparam int NAME_MAX = 64;
  localparam int SLOT_W = 8;
  localparam int NPOS_W = 6;
  localparam int NLEN_W = 7;
  localparam int MOD_W = 9;
  localparam int SUM_W = 14;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  // Request passed from the front part to the back part.
  typedef struct packed {
    logic [1:0]        mode;
    logic [6:0]        char_code;
    logic [15:0]       date;
    logic [SUM_W-1:0]  sum;
  } req_t;
endpackage

>>> src/oaht_front.sv
`timescale 1ns / 1ps
module oaht_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [24:0]     in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output oaht_pkg::req_t  q_req
);
  import oaht_pkg::*;

  // Two-entry queue; the front also keeps a running byte sum of the key name.
  req_t            q_mem_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [NLEN_W-1:0] len_r, len_nxt;
  req_t            req;
  logic            push, pop;
  logic [1:0]      mode;

  assign mode     = in_data[1:0];
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = q_mem_r[rp_r];

  always_comb begin
    req.mode      = mode;
    req.char_code = in_data[8:2];
    req.date      = {in_data[13:9], in_data[17:14], in_data[24:18]};
    req.sum       = sum_r + SUM_W'(in_data[13:9]) + SUM_W'(in_data[17:14])
                    + SUM_W'(in_data[24:18]);
    sum_nxt = sum_r;
    len_nxt = len_r;
    if (push) begin
      unique case (mode)
        MODE_BYTE: begin
          if (len_r < NLEN_W'(NAME_MAX)) begin
            sum_nxt = sum_r + SUM_W'(in_data[8:2]);
            len_nxt = len_r + 1'b1;
          end
        end
        default: begin
          sum_nxt = '0;
          len_nxt = '0;
        end
      endcase
    end
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0; sum_r <= '0; len_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
      sum_r <= sum_nxt; len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= req;
  end
endmodule

>>> src/oaht_back.sv
`timescale 1ns / 1ps
module oaht_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [8:0]      cfg_slots,
  input  logic            q_valid,
  output logic            q_ready,
  input  oaht_pkg::req_t  q_req,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata
);
  import oaht_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_CMPRD = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]        st_r, st_nxt;
  req_t              req_r;
  logic [SUM_W-1:0]  home_r;
  logic [MOD_W-1:0]  m_r, probe_r;
  logic [SLOT_W-1:0] s_r;
  logic [NPOS_W:0]   pos_r;
  logic [2:0]        status_r;
  logic [SLOT_W-1:0] slot_r;
  logic              out_v_r;

  // Key buffer and the table stores; occupancy lives in flip-flops.
  logic [6:0]        kbuf [NAME_MAX];
  logic [NLEN_W-1:0] klen_r;
  logic [SLOTS-1:0]  occ_r;
  logic [6:0]        names [SLOTS*NAME_MAX];
  logic [NLEN_W-1:0] slen [SLOTS];
  logic [15:0]       sdate [SLOTS];
  logic [NLEN_W-1:0] slen_q;
  logic [15:0]       sdate_q;
  logic [6:0]        kb_q, nm_q;

  logic [MOD_W-1:0] m_eff;
  logic [SLOT_W+NPOS_W-1:0] naddr;
  logic [NPOS_W-1:0] kb_addr;
  logic              head_match;

  always_comb begin
    m_eff = cfg_slots;
    if (cfg_slots == '0) m_eff = 9'd1;
    if (cfg_slots > 9'(SLOTS)) m_eff = 9'(SLOTS);
  end

  assign naddr    = {s_r, pos_r[NPOS_W-1:0]};
  // While storing a name the key buffer is read one byte ahead, so one byte goes per cycle.
  assign kb_addr  = (st_r == S_WR) ? NPOS_W'(pos_r[NPOS_W-1:0] + 1'b1)
                                   : pos_r[NPOS_W-1:0];
  assign head_match = (sdate_q == req_r.date) && (slen_q == klen_r);
  assign q_ready  = (st_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, status_r, slot_r};

  always_ff @(posedge clk) begin
    sdate_q <= sdate[s_r];
    slen_q  <= slen[s_r];
    kb_q    <= kbuf[kb_addr];
    nm_q    <= names[naddr];
    if (st_r == S_WR) names[naddr] <= kb_q;
    if (st_r == S_CHK && req_r.mode == MODE_INSERT && !occ_r[s_r]) begin
      slen[s_r]  <= klen_r;
      sdate[s_r] <= req_r.date;
    end
    if (q_valid && q_ready && q_req.mode == MODE_BYTE && klen_r < NLEN_W'(NAME_MAX))
      kbuf[klen_r[NPOS_W-1:0]] <= q_req.char_code;
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      req_r <= q_req;
      home_r <= q_req.sum;
    end else if (st_r == S_MOD && home_r >= SUM_W'(m_r)) begin
      home_r <= home_r - SUM_W'(m_r);
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (q_valid && q_ready)
                 st_nxt = (q_req.mode == MODE_INSERT || q_req.mode == MODE_LOOKUP)
                          ? S_MOD : S_OUT;
      S_MOD:   if (home_r < SUM_W'(m_r)) st_nxt = S_RD;
      S_RD:    st_nxt = S_CHK;
      S_CHK: begin
        if (req_r.mode == MODE_INSERT) begin
          if (occ_r[s_r]) st_nxt = S_NEXT;
          else st_nxt = (klen_r == '0) ? S_OUT : S_WR;
        end else begin
          if (!occ_r[s_r]) st_nxt = S_OUT;
          else if (head_match) st_nxt = (klen_r == '0) ? S_OUT : S_CMPRD;
          else st_nxt = S_NEXT;
        end
      end
      S_CMPRD: st_nxt = S_CMP;
      S_CMP: begin
        if (nm_q != kb_q) st_nxt = S_NEXT;
        else if (pos_r + 1'b1 == klen_r) st_nxt = S_OUT;
        else st_nxt = S_CMPRD;
      end
      S_WR:    if (pos_r + 1'b1 == klen_r) st_nxt = S_OUT;
      S_NEXT:  st_nxt = (probe_r + 1'b1 == m_r) ? S_OUT : S_RD;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_v_r <= 1'b0; klen_r <= '0; occ_r <= '0;
      status_r <= ST_BYTE; slot_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            m_r <= m_eff; probe_r <= '0; pos_r <= '0; slot_r <= '0;
            unique case (q_req.mode)
              MODE_BYTE: begin
                if (klen_r < NLEN_W'(NAME_MAX)) begin
                  klen_r <= klen_r + 1'b1; status_r <= ST_BYTE;
                end else status_r <= ST_TOO_LONG;
              end
              MODE_CLEAR: begin
                occ_r <= '0; klen_r <= '0; status_r <= ST_BYTE;
              end
              MODE_INSERT: status_r <= ST_FULL;
              default: status_r <= ST_MISSING;
            endcase
          end
        end
        S_MOD: s_r <= home_r[SLOT_W-1:0];
        S_RD: pos_r <= '0;
        S_CHK: begin
          if (req_r.mode == MODE_INSERT) begin
            if (!occ_r[s_r]) begin
              occ_r[s_r] <= 1'b1; slot_r <= s_r; status_r <= ST_INSERTED;
            end
          end else if (occ_r[s_r] && head_match && klen_r == '0) begin
            slot_r <= s_r; status_r <= ST_FOUND;
          end
        end
        S_CMP: begin
          if (nm_q == kb_q) begin
            if (pos_r + 1'b1 == klen_r) begin
              slot_r <= s_r; status_r <= ST_FOUND;
            end else pos_r <= pos_r + 1'b1;
          end
        end
        S_WR: begin
          if (pos_r + 1'b1 != klen_r) pos_r <= pos_r + 1'b1;
        end
        S_NEXT: begin
          pos_r <= '0;
          if (probe_r + 1'b1 != m_r) begin
            probe_r <= probe_r + 1'b1;
            s_r <= (9'(s_r) + 1'b1 == m_r) ? '0 : s_r + 1'b1;
          end
        end
        S_OUT: begin
          if (req_r.mode == MODE_INSERT || req_r.mode == MODE_LOOKUP) klen_r <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> src/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// A name byte or a clear goes from the idle state through the output state to its result.
// A key request first reduces the key sum modulo the slot count by repeated subtraction,
// then probes slots from the home slot; a lookup compares the name bytes on a head match,
// and an insert stores the name bytes one by one. The back part handles one request at a
// time and takes the next one the cycle after a result is taken.
// Reset (rst_n low, synchronous) empties the table, key buffer and queue; slot count 256.
module open_addressing_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[6:0], day[11:7], month[15:12], year[22:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // slot[7:0], status[10:8]
);
  import oaht_pkg::*;

  logic [8:0] slots_r;
  logic       q_valid, q_ready;
  req_t       q_req;

  // The slot count register takes effect on the next key request.
  always_ff @(posedge clk) begin
    if (!rst_n) slots_r <= 9'(SLOTS);
    else if (cfg_we) slots_r <= cfg_wdata[8:0];
  end

  // The front part sees the mode in the low bits, followed by the data fields.
  oaht_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data({in_tdata[22:0], in_tuser}), .q_valid(q_valid), .q_ready(q_ready),
    .q_req(q_req)
  );

  oaht_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_slots(slots_r), .q_valid(q_valid),
    .q_ready(q_ready), .q_req(q_req), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // A result never reports a status code beyond name too long.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:8] <= ST_TOO_LONG) else $error("bad status");
  // A held result stays put until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
endmodule
